// ===== sv/quoted_printable_decoder_unit_macros.svh =====
// Assertion macros used by the checker of the quoted-printable decoder.
`ifndef QUOTED_PRINTABLE_DECODER_UNIT_MACROS_SVH
`define QUOTED_PRINTABLE_DECODER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define QPD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define QPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== sv/qpd_pkg.sv =====
// Shared constants and types of the quoted-printable decoder.
package qpd_pkg;

    localparam logic [7:0] EQ_CHAR     = 8'h3D;
    localparam int         MAX_RESULTS = 3;

    typedef struct packed {
        logic [1:0]                  count;
        logic [MAX_RESULTS-1:0][7:0] bytes;
        logic [MAX_RESULTS-1:0]      lasts;
    } qpd_res_t;

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
               (c >= 8'h61 && c <= 8'h66);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] v;
        v = 8'h00;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = c - 8'h30;
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = c - 8'h41 + 8'd10;
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = c - 8'h61 + 8'd10;
        end
        return v[3:0];
    endfunction

endpackage

// ===== sv/qpd_core.sv =====
// Escape tracking state and per-byte decode into a list of result bytes.
module qpd_core
    import qpd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    input  logic       load,
    output qpd_res_t   res
);

    localparam logic [1:0] PEND_NONE  = 2'd0;
    localparam logic [1:0] PEND_EQ    = 2'd1;
    localparam logic [1:0] PEND_DIGIT = 2'd2;

    logic [1:0] pend_reg;
    logic [1:0] pend_next;
    logic [7:0] digit_reg;
    logic [7:0] digit_next;

    always_comb
    begin
        logic [1:0] n;
        logic       do_fresh;
        n          = 2'd0;
        do_fresh   = 1'b0;
        res        = '0;
        pend_next  = pend_reg;
        digit_next = digit_reg;
        unique case (pend_reg)
            PEND_EQ:
            begin
                if (is_hex(in_byte)) begin
                    if (in_last) begin
                        res.bytes[n] = EQ_CHAR;
                        res.lasts[n] = 1'b0;
                        n = n + 2'd1;
                        res.bytes[n] = in_byte;
                        res.lasts[n] = 1'b1;
                        n = n + 2'd1;
                        pend_next = PEND_NONE;
                    end else begin
                        digit_next = in_byte;
                        pend_next  = PEND_DIGIT;
                    end
                end else begin
                    res.bytes[n] = EQ_CHAR;
                    res.lasts[n] = 1'b0;
                    n = n + 2'd1;
                    do_fresh = 1'b1;
                end
            end
            PEND_DIGIT:
            begin
                if (is_hex(in_byte)) begin
                    res.bytes[n] = {hex_val(digit_reg), hex_val(in_byte)};
                    res.lasts[n] = in_last;
                    n = n + 2'd1;
                    pend_next = PEND_NONE;
                end else begin
                    res.bytes[n] = EQ_CHAR;
                    res.lasts[n] = 1'b0;
                    n = n + 2'd1;
                    res.bytes[n] = digit_reg;
                    res.lasts[n] = 1'b0;
                    n = n + 2'd1;
                    do_fresh = 1'b1;
                end
            end
            default:
            begin
                do_fresh = 1'b1;
            end
        endcase
        if (do_fresh) begin
            if (in_byte == EQ_CHAR && !in_last) begin
                pend_next = PEND_EQ;
            end else begin
                res.bytes[n] = in_byte;
                res.lasts[n] = in_last;
                n = n + 2'd1;
                pend_next = PEND_NONE;
            end
        end
        res.count = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pend_reg  <= PEND_NONE;
            digit_reg <= 8'h00;
        end else if (load) begin
            pend_reg  <= pend_next;
            digit_reg <= digit_next;
        end
    end

endmodule

// ===== sv/qpd_outq.sv =====
// Three-entry result register that hands decoded bytes out one per cycle unless stalled.
module qpd_outq
    import qpd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       load,
    output logic       load_ok,
    input  qpd_res_t   res,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       out_last
);

    logic [MAX_RESULTS-1:0][7:0] bytes_reg;
    logic [MAX_RESULTS-1:0][7:0] bytes_next;
    logic [MAX_RESULTS-1:0]      lasts_reg;
    logic [MAX_RESULTS-1:0]      lasts_next;
    logic [1:0]                  count_reg;
    logic [1:0]                  count_next;
    logic                        take;

    assign out_valid = (count_reg != 2'd0);
    assign take      = out_valid && !out_stall;
    assign load_ok   = (count_reg == 2'd0) || (count_reg == 2'd1 && take);
    assign load      = in_valid && load_ok;
    assign out_byte  = bytes_reg[0];
    assign out_last  = lasts_reg[0];

    always_comb
    begin
        bytes_next = bytes_reg;
        lasts_next = lasts_reg;
        count_next = count_reg;
        if (load) begin
            bytes_next = res.bytes;
            lasts_next = res.lasts;
            count_next = res.count;
        end else if (take) begin
            for (int i = 0; i < MAX_RESULTS - 1; i++) begin
                bytes_next[i] = bytes_reg[i+1];
                lasts_next[i] = lasts_reg[i+1];
            end
            bytes_next[MAX_RESULTS-1] = 8'h00;
            lasts_next[MAX_RESULTS-1] = 1'b0;
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        bytes_reg <= bytes_next;
        lasts_reg <= lasts_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
    end

endmodule

// ===== sv/quoted_printable_decoder_unit.sv =====
// Top level of the streaming quoted-printable decoder.
//
// Channel   Direction  Signals
// input     in         in_valid, in_stall, in_byte, in_last
// output    out        out_valid, out_stall, out_byte, out_last
//
// A byte is decoded in the cycle of its transfer and its results appear the next cycle.
// The result register drains one byte per cycle unless stalled, so throughput is one
// byte per cycle while each byte yields at most one result; a byte with two or three
// results holds off input. Reset clears the escape state and the result count. A
// stalled output holds input back once the result register is not draining.
module quoted_printable_decoder_unit
    import qpd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       out_last
);

    qpd_res_t res;
    logic     load;
    logic     load_ok;

    assign in_stall = !load_ok;

    qpd_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_byte (in_byte),
        .in_last (in_last),
        .load    (load),
        .res     (res)
    );

    qpd_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .load      (load),
        .load_ok   (load_ok),
        .res       (res),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .out_last  (out_last)
    );

endmodule

// ===== sv/qpd_checker.sv =====
// Port-level checker of the quoted-printable decoder and its bind.
`include "quoted_printable_decoder_unit_macros.svh"

module qpd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic [7:0] in_byte,
    input logic       in_last,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_byte,
    input logic       out_last
);

    `QPD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(out_byte) && $stable(out_last))
    `QPD_ASSERT_IMPL(a_ready_when_empty, clk, rst_n, !out_valid, !in_stall)
    `QPD_ASSERT_IMPL(a_stall_when_blocked, clk, rst_n, out_valid && out_stall, in_stall)
    `QPD_ASSERT_NEXT(a_last_yields_result, clk, rst_n, in_valid && !in_stall && in_last,
        out_valid)

endmodule

bind quoted_printable_decoder_unit qpd_checker u_qpd_checker (.*);

// ===== bench/quoted_printable_decoder_unit_tb.sv =====
// Self-checking testbench for the streaming quoted-printable decoder.
module quoted_printable_decoder_unit_tb;
    import qpd_pkg::*;

    typedef enum logic [1:0] {
        HELD_NONE  = 2'd0,
        HELD_EQ    = 2'd1,
        HELD_DIGIT = 2'd2
    } held_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } decoded_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] in_byte;
    logic       in_last;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] out_byte;
    logic       out_last;

    decoded_t   decoded_q[$];
    held_t      held;
    logic [7:0] held_digit;
    bit         bursts_on;
    int         errors;
    logic [7:0] near_hex[12] = '{8'h2F, 8'h30, 8'h39, 8'h3A, 8'h40, 8'h41,
                                 8'h46, 8'h47, 8'h60, 8'h61, 8'h66, 8'h67};

    quoted_printable_decoder_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_byte  (in_byte),
        .in_last  (in_last),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_byte (out_byte),
        .out_last (out_last)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #400000;
        $display("quoted_printable_decoder_unit_tb: done, errors");
        $finish;
    end

    function automatic logic is_hex_digit(input logic [7:0] c);
        return c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
    endfunction

    function automatic logic [3:0] digit_value(input logic [7:0] c);
        if (c <= 8'h39)
        begin
            return c[3:0];
        end
        return c[3:0] + 4'd9;
    endfunction

    function automatic void push_decoded(input logic [7:0] data, input logic last);
        decoded_t d;
        d.data = data;
        d.last = last;
        decoded_q.push_back(d);
    endfunction

    function automatic void take_unescaped(input logic [7:0] b, input logic last);
        if (b == EQ_CHAR && !last)
        begin
            held = HELD_EQ;
        end
        else
        begin
            held = HELD_NONE;
            push_decoded(b, last);
        end
    endfunction

    function automatic void predict_decode(input logic [7:0] b, input logic last);
        case (held)
            HELD_EQ:
            begin
                if (is_hex_digit(b))
                begin
                    if (last)
                    begin
                        push_decoded(EQ_CHAR, 1'b0);
                        push_decoded(b, 1'b1);
                        held = HELD_NONE;
                    end
                    else
                    begin
                        held_digit = b;
                        held = HELD_DIGIT;
                    end
                end
                else
                begin
                    push_decoded(EQ_CHAR, 1'b0);
                    take_unescaped(b, last);
                end
            end
            HELD_DIGIT:
            begin
                if (is_hex_digit(b))
                begin
                    push_decoded({digit_value(held_digit), digit_value(b)}, last);
                    held = HELD_NONE;
                end
                else
                begin
                    push_decoded(EQ_CHAR, 1'b0);
                    push_decoded(held_digit, 1'b0);
                    take_unescaped(b, last);
                end
            end
            default:
            begin
                take_unescaped(b, last);
            end
        endcase
    endfunction

    function automatic logic [7:0] pick_hex();
        int r;
        r = $urandom_range(0, 21);
        if (r < 10)
        begin
            return 8'(8'h30 + r);
        end
        else if (r < 16)
        begin
            return 8'(8'h41 + r - 10);
        end
        return 8'(8'h61 + r - 16);
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last);
        if (bursts_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        in_last  <= last;
        do @(posedge clk); while (in_stall);
        predict_decode(b, last);
    endtask

    task automatic send_text(input string s);
        foreach (s[i])
        begin
            send_byte(s[i], i == s.len() - 1);
        end
    endtask

    task automatic send_random_string(output int count);
        logic [7:0] txt[$];
        int         units;
        units = $urandom_range(1, 6);
        repeat (units)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                begin
                    txt.push_back(EQ_CHAR);
                    txt.push_back(pick_hex());
                    txt.push_back(pick_hex());
                end
                4: txt.push_back(near_hex[4'($urandom_range(0, 11))]);
                5: txt.push_back(EQ_CHAR);
                6:
                begin
                    txt.push_back(EQ_CHAR);
                    txt.push_back(pick_hex());
                end
                default: txt.push_back(8'($urandom_range(0, 255)));
            endcase
        end
        foreach (txt[i])
        begin
            send_byte(txt[i], i == txt.size() - 1);
        end
        count = txt.size();
    endtask

    task automatic wait_drained();
        int guard;
        guard = 0;
        while (decoded_q.size() != 0 && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
    endtask

    task automatic test_escapes_directed();
        send_text("=41");
        send_text("=fF");
        send_text("=0");
        send_text("=");
        send_text("==3d");
        send_text("=9G");
        send_text("=4=");
        send_text("=g");
        send_byte(EQ_CHAR, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
    endtask

    task automatic test_random_streams(input int items);
        int sent;
        int n;
        sent = 0;
        while (sent < items)
        begin
            bursts_on = ($urandom_range(0, 3) != 0);
            send_random_string(n);
            sent += n;
        end
        bursts_on = 1'b1;
    endtask

    task automatic test_pause_until_drained();
        int n;
        send_random_string(n);
        in_valid <= 1'b0;
        wait_drained();
        send_random_string(n);
    endtask

    task automatic test_back_to_back(input int items);
        int sent;
        int n;
        bursts_on = 1'b0;
        sent = 0;
        while (sent < items)
        begin
            send_random_string(n);
            sent += n;
        end
    endtask

    initial
    begin
        int hold;
        hold = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                hold--;
            end
            else if (bursts_on && $urandom_range(0, 4) == 0)
            begin
                out_stall <= 1'b1;
                hold = $urandom_range(0, 3);
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        decoded_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (decoded_q.size() == 0)
            begin
                $display("%0t: unexpected transfer, got byte %h last %b",
                         $time, out_byte, out_last);
                errors++;
            end
            else
            begin
                want = decoded_q.pop_front();
                if (out_byte !== want.data || out_last !== want.last)
                begin
                    $display("%0t: mismatch, expected byte %h last %b, got byte %h last %b",
                             $time, want.data, want.last, out_byte, out_last);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        errors     = 0;
        held       = HELD_NONE;
        held_digit = 8'h00;
        bursts_on  = 1'b1;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_byte   <= 8'h00;
        in_last   <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_escapes_directed();
        test_random_streams(200);
        test_pause_until_drained();
        test_random_streams(40);
        test_back_to_back(50);

        in_valid <= 1'b0;
        wait_drained();
        repeat (8) @(posedge clk);
        if (decoded_q.size() != 0)
        begin
            $display("%0t: %0d expected transfers never arrived", $time, decoded_q.size());
            errors++;
        end
        if (errors == 0)
        begin
            $display("quoted_printable_decoder_unit_tb: done, clean");
        end
        else
        begin
            $display("quoted_printable_decoder_unit_tb: done, errors");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/qpd_pkg.sv
sv/qpd_core.sv
sv/qpd_outq.sv
sv/quoted_printable_decoder_unit.sv
sv/qpd_checker.sv
bench/quoted_printable_decoder_unit_tb.sv
